// File: rtl/twc_pkg.sv
// ----------------------------------------------------------------------------
// twc_pkg: Tukey window coefficient package
// Shared widths, outcome codes and cosine series terms.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int unsigned DefMaxLength = 4096;

  localparam int unsigned LenW   = 13;
  localparam int unsigned FracW  = 17;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned CoefW  = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned NumW = 30;
  localparam int unsigned DenW = 31;
  localparam int unsigned RemW = 47;
  localparam int unsigned QuoW = 16;
  localparam int unsigned ZW   = 30;
  localparam int unsigned AccW = 33;

  localparam logic [CfgIdxW-1:0] RegWindowLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFlatFraction = 2'd1;

  localparam logic [LenW-1:0]  ResetLength   = 13'd256;
  localparam logic [FracW-1:0] ResetFraction = 17'd44564;
  localparam logic [FracW-1:0] OneQ16        = 17'd65536;
  localparam logic [CoefW-1:0] HalfQ16       = 17'd32768;
  localparam logic [AccW-1:0]  OneQ30        = 33'd1073741824;

  typedef enum logic [1:0] {
    KIND_TAPER  = 2'd0,
    KIND_FLAT   = 2'd1,
    KIND_ALPHA1 = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_e;

  localparam logic [AccW-1:0] CosTerm [6] = '{
    33'd5298703516, 33'd4358008962, 33'd1433727482,
    33'd252684340, 33'd27709939, 33'd2071865
  };

  function automatic logic [AccW-1:0] sub_floor0(logic [AccW-1:0] a, logic [AccW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

// File: rtl/tukey_window_coefficient.sv
// ----------------------------------------------------------------------------
// tukey_window_coefficient: centered Tukey window coefficient pipeline
//
// Send a sample index as one beat on the input channel (in_valid_i /
// in_ready_o with sample_index_i). One beat returns on the output channel
// (out_valid_o / out_ready_i) with a Q1.16 coefficient and an error flag,
// in the order the indices went in.
// The window length and flat fraction are set through the configuration
// channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i); write them
// only while no beat is in flight. cfg_ready_o is always high.
// Throughput is one beat per cycle while the receiver keeps up: a setup
// stage, sixteen restoring divide stages (one quotient bit each), a squaring
// stage, six cosine series stages and an output stage. Each stage holds its
// own valid bit.
// When the receiver stalls, the output stage holds and earlier stages
// keep filling empty slots; input ready drops only once every stage is
// full. Reset empties the pipeline and loads length 256, fraction 44564.
// ----------------------------------------------------------------------------
module tukey_window_coefficient
  import twc_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = DefMaxLength
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IdxW-1:0]     sample_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoefW-1:0]    coefficient_o,
  output logic                error_flag_o
);

  localparam int unsigned NDiv    = QuoW;
  localparam int unsigned SqStg   = NDiv + 1;
  localparam int unsigned HStg0   = SqStg + 1;
  localparam int unsigned NHorner = 6;
  localparam int unsigned FinStg  = HStg0 + NHorner;
  localparam int unsigned NStg    = FinStg + 1;
  localparam logic [FracW-1:0] MaxLenW = FracW'(MAX_LENGTH);

  logic [LenW-1:0]  len_q;
  logic [FracW-1:0] frac_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= ResetLength;
      frac_q <= ResetFraction;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWindowLength: len_q  <= cfg_data_i[LenW-1:0];
        RegFlatFraction: frac_q <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;
  kind_e           kind_q [NStg];
  kind_e           kind_s;

  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) kind_q[0] <= kind_s;
    for (int k = 1; k < NStg; k++) begin
      if (en[k]) kind_q[k] <= kind_q[k-1];
    end
  end

  // setup stage
  logic [LenW-1:0]  n_s;
  logic [FracW-1:0] a_s;
  logic [LenW-1:0]  i2_s;
  logic [LenW-1:0]  d_s;
  logic [NumW-1:0]  flat_lim_s;
  logic [NumW-1:0]  dq_s;
  logic [NumW-1:0]  num_s;
  logic [DenW-1:0]  den_s;

  always_comb begin
    n_s = ({{(FracW-LenW){1'b0}}, len_q} > MaxLenW) ? MaxLenW[LenW-1:0] : len_q;
    a_s = (frac_q > OneQ16) ? OneQ16 : frac_q;
    i2_s = {sample_index_i, 1'b0};
    d_s = (i2_s >= n_s) ? (i2_s - n_s) : (n_s - i2_s);
    flat_lim_s = NumW'(a_s * n_s);
    dq_s = {1'b0, d_s, 16'b0};
    num_s = dq_s - flat_lim_s;
    den_s = {NumW'((OneQ16 - a_s) * n_s), 1'b0};
    if ({1'b0, sample_index_i} >= n_s) begin
      kind_s = KIND_RANGE;
    end else if (dq_s < flat_lim_s) begin
      kind_s = KIND_FLAT;
    end else if (a_s == OneQ16) begin
      kind_s = KIND_ALPHA1;
    end else begin
      kind_s = KIND_TAPER;
    end
  end

  logic [RemW-1:0] rem_q [NDiv+1];
  logic [QuoW-1:0] quo_q [NDiv+1];
  logic [DenW-1:0] den_q [NDiv+1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0]  <= {num_s, 16'b0} + RemW'(den_s >> 1);
      quo_q[0]  <= '0;
      den_q[0]  <= den_s;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= NDiv; k++) begin : g_div
    localparam int unsigned Bit = NDiv - k;
    logic [RemW-1:0] sh;
    assign sh = RemW'(den_q[k-1]) << Bit;
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        den_q[k] <= den_q[k-1];
        if (rem_q[k-1] >= sh) begin
          rem_q[k] <= rem_q[k-1] - sh;
          quo_q[k] <= quo_q[k-1] | (QuoW'(1) << Bit);
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  logic [ZW-1:0]   z_q   [NStg];
  logic [AccW-1:0] acc_q [NStg];
  logic [2*QuoW-1:0] sq;

  assign sq = quo_q[NDiv] * quo_q[NDiv];

  always_ff @(posedge clk_i) begin
    if (en[SqStg]) begin
      z_q[SqStg]   <= ZW'(sq >> 2);
      acc_q[SqStg] <= CosTerm[5];
    end
  end

  // cosine series, one Horner step per stage
  for (genvar h = 0; h < NHorner; h++) begin : g_horner
    localparam int unsigned S = HStg0 + h;
    logic [ZW+AccW-1:0] prod;
    logic [AccW-1:0]    term;
    assign prod = z_q[S-1] * acc_q[S-1];
    if (h == NHorner - 1) begin : g_last
      assign term = OneQ30;
    end else begin : g_mid
      assign term = CosTerm[NHorner-2-h];
    end
    always_ff @(posedge clk_i) begin
      if (en[S]) begin
        z_q[S]   <= z_q[S-1];
        acc_q[S] <= sub_floor0(term, AccW'(prod >> 30));
      end
    end
  end

  logic [AccW-1:0]  rnd;
  logic [CoefW-1:0] taper;
  logic [CoefW-1:0] coef_q;
  logic             err_q;

  assign rnd   = (acc_q[FinStg-1] + AccW'(16384)) >> 15;
  assign taper = HalfQ16 + CoefW'(rnd);

  always_ff @(posedge clk_i) begin
    if (en[FinStg]) begin
      case (kind_q[FinStg-1])
        KIND_RANGE: begin
          coef_q <= '0;
          err_q  <= 1'b1;
        end
        KIND_FLAT: begin
          coef_q <= OneQ16;
          err_q  <= 1'b0;
        end
        KIND_ALPHA1: begin
          coef_q <= OneQ16;
          err_q  <= 1'b1;
        end
        default: begin
          coef_q <= (taper > OneQ16) ? OneQ16 : taper;
          err_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o   = vld_q[FinStg];
  assign coefficient_o = coef_q;
  assign error_flag_o  = err_q;

  a_err_coef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> coefficient_o == '0 || coefficient_o == OneQ16)
    else $error("error beat with unexpected coefficient");

  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_flag_o |-> coefficient_o >= HalfQ16 && coefficient_o <= OneQ16)
    else $error("coefficient outside taper range");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && (&vld_q))
    else $error("input stalled without full pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coefficient_o))
    else $error("output beat lost under stall");

endmodule

// File: tb/sv/tb_tukey_window_coefficient.sv
// ----------------------------------------------------------------------------
// tb_tukey_window_coefficient: self-checking bench for the Tukey window block
// Streams sample indices under several window settings, predicts every
// coefficient and flag in fixed point, and compares each output beat in
// order while both channels idle and stall at random in some phases.
// ----------------------------------------------------------------------------
module tb_tukey_window_coefficient
  import twc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic             err;
  } coef_t;

  localparam int unsigned LenCap = 4096;
  localparam int unsigned CycleLimit = 400000;
  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned CosQ30 [6] = '{
    64'd5298703516, 64'd4358008962, 64'd1433727482,
    64'd252684340, 64'd27709939, 64'd2071865
  };
  localparam logic [CfgIdxW-1:0] RegSpare0 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare1 = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [IdxW-1:0]     sample_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CoefW-1:0]    coefficient_o;
  logic                error_flag_o;

  logic [LenW-1:0]  cur_length = ResetLength;
  logic [FracW-1:0] cur_fraction = ResetFraction;
  logic [IdxW-1:0]  index_q [$];
  coef_t            coef_q [$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      holdoff_left = 0;
  bit               holdoff_req = 1'b0;
  int unsigned      errors = 0;
  int unsigned      beats_in = 0;
  int unsigned      beats_out = 0;
  int unsigned      cycles = 0;

  logic [IdxW-1:0] dir_reset [10] = '{12'd0, 12'd1, 12'd127, 12'd128, 12'd255,
                                      12'd256, 12'd4095, 12'd40, 12'd30, 12'd2048};
  logic [IdxW-1:0] dir_long  [5]  = '{12'd0, 12'd4095, 12'd2048, 12'd1024, 12'd3000};
  logic [IdxW-1:0] dir_alpha [5]  = '{12'd0, 12'd50, 12'd99, 12'd100, 12'd25};
  logic [IdxW-1:0] dir_zero  [2]  = '{12'd0, 12'd4095};

  tukey_window_coefficient uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned floor_sub(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic coef_t tukey_coef(logic [IdxW-1:0] idx, logic [LenW-1:0] len,
                                       logic [FracW-1:0] frac);
    longint unsigned n, a, i, d, lim, num, den, r, z, acc, c;
    coef_t res;
    n = (len > LenCap) ? LenCap : len;
    a = (frac > OneQ16) ? OneQ16 : frac;
    i = idx;
    if (i >= n) begin
      res.coef = '0;
      res.err = 1'b1;
      return res;
    end
    d = (2 * i >= n) ? 2 * i - n : n - 2 * i;
    lim = a * n;
    if (d * 65536 < lim) begin
      res.coef = OneQ16;
      res.err = 1'b0;
      return res;
    end
    if (a >= 65536) begin
      res.coef = OneQ16;
      res.err = 1'b1;
      return res;
    end
    num = d * 65536 - lim;
    den = 2 * (65536 - a) * n;
    r = (num * 65536 + den / 2) / den;
    if (r > 32768) r = 32768;
    z = (r * r) >> 2;
    acc = CosQ30[5];
    for (int k = 4; k >= 0; k--) acc = floor_sub(CosQ30[k], (z * acc) >> 30);
    acc = floor_sub(Q30, (z * acc) >> 30);
    c = 32768 + ((acc + 16384) >> 15);
    if (c > 65536) c = 65536;
    res.coef = c[CoefW-1:0];
    res.err = 1'b0;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic offer;
    if (in_valid_i && in_ready_o) begin
      coef_q.push_back(tukey_coef(sample_index_i, cur_length, cur_fraction));
      beats_in++;
    end
    if (in_valid_i && !in_ready_o) begin
      offer = 1'b1;
    end else if (index_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      offer = 1'b1;
      sample_index_i <= index_q.pop_front();
    end else begin
      offer = 1'b0;
    end
    in_valid_i <= offer;
  end

  // monitor
  always @(posedge clk_i) begin
    coef_t exp_beat;
    if (out_valid_o && out_ready_i) begin
      beats_out++;
      if (coef_q.size() == 0) begin
        $error("unexpected beat: coefficient %0d error_flag %0d", coefficient_o,
               error_flag_o);
        errors++;
      end else begin
        exp_beat = coef_q.pop_front();
        if (coefficient_o !== exp_beat.coef) begin
          $error("coefficient: expected %0d, got %0d", exp_beat.coef, coefficient_o);
          errors++;
        end
        if (error_flag_o !== exp_beat.err) begin
          $error("error_flag: expected %0d, got %0d", exp_beat.err, error_flag_o);
          errors++;
        end
      end
    end
    if (holdoff_req && holdoff_left == 0) holdoff_left = 300;
    if (holdoff_left > 0) begin
      holdoff_left--;
      if (holdoff_left == 0) holdoff_req = 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, coef_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (index_q.size() > 0 || in_valid_i || coef_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegWindowLength) cur_length = data[LenW-1:0];
    if (idx == RegFlatFraction) cur_fraction = data[FracW-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] len, logic [CfgDataW-1:0] frac,
                           int unsigned count, int unsigned mode);
    int unsigned n;
    drain();
    write_reg(RegWindowLength, len);
    write_reg(RegFlatFraction, frac);
    send_idle_pct = (mode == 1) ? 54 : (mode == 3) ? 34 : 0;
    recv_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 34 : 0;
    n = (cur_length > LenCap) ? LenCap : cur_length;
    for (int k = 0; k < count; k++) begin
      if (n == 0 || $urandom_range(9) == 0) index_q.push_back(IdxW'($urandom));
      else index_q.push_back(IdxW'($urandom_range(n - 1)));
      if (k == count / 2 && mode == 0) begin
        while (index_q.size() > 0 || in_valid_i || coef_q.size() > 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, edges, flat, taper, out of range
    foreach (dir_reset[k]) index_q.push_back(dir_reset[k]);
    drain();
    write_reg(RegWindowLength, 32'd4096);
    write_reg(RegFlatFraction, 32'd0);
    foreach (dir_long[k]) index_q.push_back(dir_long[k]);
    drain();
    write_reg(RegSpare0, 32'hFFFF_FFFF);
    write_reg(RegSpare1, 32'h0);
    write_reg(RegWindowLength, 32'd100);
    write_reg(RegFlatFraction, 32'd65536);
    foreach (dir_alpha[k]) index_q.push_back(dir_alpha[k]);
    drain();
    write_reg(RegWindowLength, 32'd0);
    foreach (dir_zero[k]) index_q.push_back(dir_zero[k]);

    run_phase(256, 44564, 150, 0);
    run_phase(4096, 0, 150, 1);
    run_phase(8191, 131071, 150, 2);
    run_phase(1, 65535, 100, 3);
    run_phase(2, 1, 150, 0);
    holdoff_req = 1'b1;
    run_phase(37, 30000, 200, 1);
    run_phase(5000, 65535, 150, 3);
    run_phase(4096, 32768, 150, 2);
    run_phase(100, 65536, 100, 0);
    run_phase(0, 12345, 50, 1);
    for (int p = 0; p < 4; p++)
      run_phase($urandom, $urandom, 150, p);
    drain();

    $display("covered %0d index beats, %0d result beats over directed and random settings",
             beats_in, beats_out);
    $display("idle and stall mixes on both channels, long receiver hold-off, sender pauses");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/twc_pkg.sv
rtl/tukey_window_coefficient.sv
tb/sv/tb_tukey_window_coefficient.sv
